// ----- rtl/tem_pkg.sv -----
// tem_pkg: shared constants, codes and types for the text extent measure block
// no dependencies; imported by text_extent_measure and tem_checker
`timescale 1ns / 1ps
`default_nettype none

package tem_pkg;

    localparam int MAX_RANGES = 8;
    localparam int MAX_GLYPHS = 64;
    localparam int PAIR_DEPTH = MAX_GLYPHS * MAX_GLYPHS;

    // field widths fixed by the interface
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 12;
    localparam int CODE_W   = 16;
    localparam int LEN_W    = 7;
    localparam int VAL_W    = 16;
    localparam int WIDTH_W  = 32;
    localparam int HEIGHT_W = 15;
    localparam int NRANGE_W = 4;
    localparam int GTOTAL_W = 7;
    localparam int CFG_IDX_W = 1;

    // derived widths
    localparam int RIDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int GIDX_W = $clog2(MAX_GLYPHS);
    localparam int PADR_W = $clog2(PAIR_DEPTH);
    localparam int BASE_W = LEN_W + $clog2(MAX_RANGES + 1);
    localparam int GSUM_W = BASE_W + 1;

    // result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD_RANGE  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_HEIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_PAIR   = 2'd2;
    localparam logic [OP_W-1:0] OP_CHAR        = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_RANGES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_TOTAL   = 1'd1;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/text_extent_measure.sv -----
// text_extent_measure: maps characters to glyphs, sums kerning pair advances, tracks max height
// depends on tem_pkg
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_stall  | op, slot, char_code, range_len, entry_value,
//          |                      | last_char
//  out     | out_valid / out_stall| text_width, text_height
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item per cycle while in_stall is low; a result is offered once stage 2 queues it
// stage 0 compares the range table, stage 1 addresses height and pair advance memories
// loads write their table at the accept edge; a result queue of four entries
// decouples the output, and in_stall rises only when four results are owed
// reset clears ranges and accumulators; height and advance memories hold garbage until written
`timescale 1ns / 1ps
`default_nettype none

module text_extent_measure (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire  [tem_pkg::OP_W-1:0]       op,
    input  wire  [tem_pkg::SLOT_W-1:0]     slot,
    input  wire  [tem_pkg::CODE_W-1:0]     char_code,
    input  wire  [tem_pkg::LEN_W-1:0]      range_len,
    input  wire  signed [tem_pkg::VAL_W-1:0] entry_value,
    input  wire                            last_char,
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic signed [tem_pkg::WIDTH_W-1:0] text_width,
    output logic [tem_pkg::HEIGHT_W-1:0]   text_height,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [tem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [31:0]                    cfg_data
);
    import tem_pkg::*;

    // configuration
    logic [NRANGE_W-1:0] active_ranges_reg;
    logic [GTOTAL_W-1:0] glyph_total_reg;

    // range table
    logic [CODE_W-1:0] range_start_reg [MAX_RANGES];
    logic [LEN_W-1:0]  range_len_reg   [MAX_RANGES];

    // memories
    logic [VAL_W-1:0] height_mem [MAX_GLYPHS];
    logic [VAL_W-1:0] pair_mem   [PAIR_DEPTH];

    // stage 1
    logic              s1_valid_reg;
    logic              s1_hit_reg;
    logic              s1_last_reg;
    logic [RIDX_W-1:0] s1_ridx_reg;
    logic [LEN_W-1:0]  s1_offset_reg;

    // stage 2
    logic             s2_valid_reg;
    logic             s2_mapped_reg;
    logic             s2_pair_reg;
    logic             s2_last_reg;
    logic [VAL_W-1:0] height_rd_reg;
    logic [VAL_W-1:0] pair_rd_reg;

    // pending glyph and accumulators
    logic              pend_valid_reg;
    logic [GIDX_W-1:0] pend_glyph_reg;
    logic [WIDTH_W-1:0]  width_sum_reg;
    logic [HEIGHT_W-1:0] height_max_reg;

    // result queue
    result_t              oq_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  oq_wr_ptr_reg;
    logic [OQ_PTR_W-1:0]  oq_rd_ptr_reg;
    logic [OQ_CNT_W-1:0]  oq_count_reg;

    logic in_accept;
    logic char_accept;
    logic oq_push;
    logic oq_pop;

    // stage 0 combinational
    logic [NRANGE_W-1:0] n_ranges;
    logic                hit_next;
    logic [RIDX_W-1:0]   ridx_next;
    logic [LEN_W-1:0]    offset_next;

    // stage 1 combinational
    logic [GTOTAL_W-1:0] eff_glyphs;
    logic [BASE_W-1:0]   base_sum;
    logic [GSUM_W-1:0]   glyph_full;
    logic                mapped;
    logic [GIDX_W-1:0]   glyph;
    logic [PADR_W+GTOTAL_W-1:0] pair_prod;
    logic [PADR_W-1:0]   pair_addr;

    // stage 2 combinational
    logic [WIDTH_W-1:0]  width_new;
    logic [HEIGHT_W-1:0] height_new;
    logic [2:0]          owed_inflight;

    assign cfg_ready   = 1'b1;
    assign in_accept   = in_valid && !in_stall;
    assign char_accept = in_accept && (op == OP_CHAR);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_ranges_reg <= '0;
            glyph_total_reg   <= GTOTAL_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ACTIVE_RANGES: active_ranges_reg <= cfg_data[NRANGE_W-1:0];
                REG_GLYPH_TOTAL:   glyph_total_reg   <= cfg_data[GTOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    // range table loads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_RANGES; i++)
            begin
                range_start_reg[i] <= '0;
                range_len_reg[i]   <= '0;
            end
        end
        else if (in_accept && op == OP_LOAD_RANGE && 32'(slot) < MAX_RANGES)
        begin
            range_start_reg[slot[RIDX_W-1:0]] <= char_code;
            range_len_reg[slot[RIDX_W-1:0]]   <= range_len;
        end
    end

    // stage 0: first matching range and offset into it
    always_comb
    begin
        n_ranges    = (32'(active_ranges_reg) > MAX_RANGES) ? NRANGE_W'(MAX_RANGES)
                                                             : active_ranges_reg;
        hit_next    = 1'b0;
        ridx_next   = '0;
        offset_next = '0;
        for (int i = MAX_RANGES - 1; i >= 0; i--)
        begin
            if (32'(i) < 32'(n_ranges) && char_code >= range_start_reg[i]
                && (char_code - range_start_reg[i]) < CODE_W'(range_len_reg[i]))
            begin
                hit_next    = 1'b1;
                ridx_next   = RIDX_W'(i);
                offset_next = LEN_W'(char_code - range_start_reg[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= char_accept;
    end

    always_ff @(posedge clk)
    begin
        if (char_accept)
        begin
            s1_hit_reg    <= hit_next;
            s1_last_reg   <= last_char;
            s1_ridx_reg   <= ridx_next;
            s1_offset_reg <= offset_next;
        end
    end

    // stage 1: glyph index and pair address
    always_comb
    begin
        eff_glyphs = (32'(glyph_total_reg) > MAX_GLYPHS) ? GTOTAL_W'(MAX_GLYPHS)
                                                          : glyph_total_reg;
        base_sum = '0;
        for (int i = 0; i < MAX_RANGES; i++)
        begin
            if (RIDX_W'(i) < s1_ridx_reg)
                base_sum = base_sum + BASE_W'(range_len_reg[i]);
        end
        glyph_full = GSUM_W'(base_sum) + GSUM_W'(s1_offset_reg);
        mapped     = s1_hit_reg && (glyph_full < GSUM_W'(eff_glyphs));
        glyph      = glyph_full[GIDX_W-1:0];
        // pending < eff and glyph < eff keep the address below eff squared
        pair_prod  = (PADR_W+GTOTAL_W)'(pend_glyph_reg) * (PADR_W+GTOTAL_W)'(eff_glyphs)
                   + (PADR_W+GTOTAL_W)'(glyph);
        pair_addr  = pair_prod[PADR_W-1:0];
    end

    // height memory
    always_ff @(posedge clk)
    begin
        if (in_accept && op == OP_LOAD_HEIGHT && 32'(slot) < MAX_GLYPHS)
            height_mem[slot[GIDX_W-1:0]] <= entry_value;
        height_rd_reg <= height_mem[glyph];
    end

    // pair advance memory
    always_ff @(posedge clk)
    begin
        if (in_accept && op == OP_LOAD_PAIR && 32'(slot) < PAIR_DEPTH)
            pair_mem[slot[PADR_W-1:0]] <= entry_value;
        pair_rd_reg <= pair_mem[pair_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_glyph_reg <= '0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                pend_valid_reg <= mapped && !s1_last_reg;
                pend_glyph_reg <= (mapped && !s1_last_reg) ? glyph : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_mapped_reg <= mapped;
            s2_pair_reg   <= mapped && pend_valid_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // stage 2: accumulate
    always_comb
    begin
        width_new  = width_sum_reg;
        height_new = height_max_reg;
        if (s2_pair_reg)
            width_new = width_sum_reg + {{(WIDTH_W-VAL_W){pair_rd_reg[VAL_W-1]}}, pair_rd_reg};
        if (s2_mapped_reg && !height_rd_reg[VAL_W-1]
            && height_rd_reg[HEIGHT_W-1:0] > height_max_reg)
            height_new = height_rd_reg[HEIGHT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_sum_reg  <= '0;
            height_max_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            width_sum_reg  <= s2_last_reg ? '0 : width_new;
            height_max_reg <= s2_last_reg ? '0 : height_new;
        end
    end

    // result queue
    assign oq_push = s2_valid_reg && s2_last_reg;
    assign oq_pop  = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_mem[oq_wr_ptr_reg] <= '{width: width_new, height: height_new};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            if (oq_push)
                oq_wr_ptr_reg <= oq_wr_ptr_reg + 1'b1;
            if (oq_pop)
                oq_rd_ptr_reg <= oq_rd_ptr_reg + 1'b1;
            case ({oq_push, oq_pop})
                2'b10:   oq_count_reg <= oq_count_reg + 1'b1;
                2'b01:   oq_count_reg <= oq_count_reg - 1'b1;
                default: oq_count_reg <= oq_count_reg;
            endcase
        end
    end

    assign out_valid   = (oq_count_reg != '0);
    assign text_width  = oq_mem[oq_rd_ptr_reg].width;
    assign text_height = oq_mem[oq_rd_ptr_reg].height;

    // every last character still in the pipe owns a queue slot
    assign owed_inflight = 3'(s1_valid_reg && s1_last_reg) + 3'(s2_valid_reg && s2_last_reg);
    assign in_stall = (32'(oq_count_reg) + 32'(owed_inflight)) >= OQ_DEPTH;

endmodule

`default_nettype wire

// ----- rtl/tem_checker.sv -----
// tem_checker: port-level checks on text_extent_measure, attached by bind
// depends on tem_pkg and the text_extent_measure port list
`timescale 1ns / 1ps
`default_nettype none

module tem_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            in_valid,
    input wire                            in_stall,
    input wire [tem_pkg::OP_W-1:0]        op,
    input wire                            last_char,
    input wire                            out_valid,
    input wire                            out_stall,
    input wire [tem_pkg::WIDTH_W-1:0]     text_width,
    input wire [tem_pkg::HEIGHT_W-1:0]    text_height
);
    import tem_pkg::*;

    logic [3:0] owed_reg;
    logic       last_in;
    logic       result_out;

    assign last_in    = in_valid && !in_stall && op == OP_CHAR && last_char;
    assign result_out = out_valid && !out_stall;

    // results owed: last characters accepted minus transactions delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            owed_reg <= '0;
        else
            owed_reg <= owed_reg + 4'(last_in) - 4'(result_out);
    end

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(text_width) && $stable(text_height))
        else $error("stalled result changed");

    a_no_result_unowed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> owed_reg != 4'd0)
        else $error("result without a last character");

    a_owed_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg <= 4'(OQ_DEPTH))
        else $error("more results owed than the queue holds");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg == 4'd0 |-> !in_stall)
        else $error("input stalled with nothing owed");

endmodule

bind text_extent_measure tem_checker u_tem_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .last_char  (last_char),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .text_width (text_width),
    .text_height(text_height)
);

`default_nettype wire
